@@ design/glcm_pkg.sv @@
// Shared constants, codes, controller/datapath bundles and helpers for the co-occurrence counter.
`default_nettype none

package glcm_pkg;

	// Frame and bin array geometry.
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int LEVELS     = 256;
	localparam int COUNT_BITS = 20;

	// Fixed field widths of the ports.
	localparam int PIX_BITS     = 8;
	localparam int POSIN_BITS   = 8;
	localparam int VALUE_BITS   = 20;
	localparam int CFG_BITS     = 9;
	localparam int CFG_IDX_BITS = 2;
	localparam int MODE_BITS    = 2;

	// Derived widths.
	localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_BITS   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int LEVEL_BITS = $clog2(LEVELS);
	localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int FRAME_AW   = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam int BIN_DEPTH  = LEVELS * LEVELS;
	localparam int BIN_AW     = $clog2(BIN_DEPTH);
	localparam int RC_BITS    = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
	localparam int POS_BITS   = (RC_BITS > CFG_BITS) ? RC_BITS + 1 : CFG_BITS;
	localparam int SUM_BITS   = POS_BITS + 2;

	localparam logic [VALUE_BITS-1:0] OUT_MAX = '1;

	// Input item modes.
	localparam logic [MODE_BITS-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_PASS  = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd3;

	// Result kinds.
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_PASS = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_X = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_Y = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_pix;
		logic start_pass;
		logic fetch;
		logic bin_rd_pass;
		logic bin_rd_user;
		logic bin_wr;
		logic advance;
		logic clr_step;
		logic out_read;
		logic out_pass;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic frame_empty;
		logic scan_last;
		logic nbr_in_frame;
		logic clr_last;
	} sts_t;

	// Gray levels past the bin range select the last bin.
	function automatic logic [LEVEL_BITS-1:0] clamp_level(input logic [PIX_BITS-1:0] lv);
		clamp_level = (32'(lv) >= LEVELS) ? LEVEL_BITS'(LEVELS - 1) : LEVEL_BITS'(lv);
	endfunction

	// Counts wider than the result field are reported at its maximum.
	function automatic logic [VALUE_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
		sat_out = (64'(v) > 64'(OUT_MAX)) ? OUT_MAX : VALUE_BITS'(v);
	endfunction

endpackage

`default_nettype wire

@@ design/glcm_ctrl.sv @@
// Controller state machine for the co-occurrence counter: handshakes and sequencing.
`default_nettype none

module glcm_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [glcm_pkg::MODE_BITS-1:0] mode,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	input  wire glcm_pkg::sts_t                sts,
	output glcm_pkg::cmd_t                     cmd
);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_BINRD = 3'd3;
	localparam logic [2:0] S_BINWR = 3'd4;
	localparam logic [2:0] S_PDONE = 3'd5;
	localparam logic [2:0] S_RDOUT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;
	logic       in_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Next state and command decode.
	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_fire) begin
					case (mode)
						glcm_pkg::MODE_LOAD: begin
							cmd.load_pix = 1'b1;
						end
						glcm_pkg::MODE_PASS: begin
							cmd.start_pass = 1'b1;
							state_nxt = sts.frame_empty ? S_PDONE : S_FETCH;
						end
						glcm_pkg::MODE_READ: begin
							cmd.bin_rd_user = 1'b1;
							state_nxt = S_RDOUT;
						end
						default: begin
							state_nxt = S_CLR;
						end
					endcase
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				if (sts.nbr_in_frame) begin
					state_nxt = S_BINRD;
				end else begin
					cmd.advance = 1'b1;
					if (sts.scan_last) begin
						state_nxt = S_PDONE;
					end
				end
			end
			S_BINRD: begin
				cmd.bin_rd_pass = 1'b1;
				state_nxt = S_BINWR;
			end
			S_BINWR: begin
				cmd.bin_wr  = 1'b1;
				cmd.advance = 1'b1;
				state_nxt = sts.scan_last ? S_PDONE : S_FETCH;
			end
			S_PDONE: begin
				if (out_free) begin
					cmd.out_pass = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_RDOUT: begin
				if (out_free) begin
					cmd.out_read = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register; reset starts with the bin clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Output valid flag for the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_read || cmd.out_pass) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_out_from_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RDOUT || $past(state_q) == S_PDONE))
		else $error("result flagged outside a result state");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_read || cmd.out_pass) |-> out_free)
		else $error("pending result overwritten");
	a_clear_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && mode == glcm_pkg::MODE_CLEAR) |=> (state_q == S_CLR))
		else $error("clear transaction did not start a sweep");
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bin_wr |-> $past(cmd.bin_rd_pass))
		else $error("bin written without a preceding read");
`endif

endmodule

`default_nettype wire

@@ design/glcm_dp.sv @@
// Datapath for the co-occurrence counter: config, frame store, bin store, scan and result.
`default_nettype none

module glcm_dp (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_we,
	input  wire logic [glcm_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  wire logic [glcm_pkg::CFG_BITS-1:0]            cfg_data,
	input  wire logic [glcm_pkg::PIX_BITS-1:0]            pixel,
	input  wire logic [glcm_pkg::POSIN_BITS-1:0]          row,
	input  wire logic [glcm_pkg::POSIN_BITS-1:0]          col,
	input  wire logic [glcm_pkg::PIX_BITS-1:0]            level_ref,
	input  wire logic [glcm_pkg::PIX_BITS-1:0]            level_nbr,
	input  wire glcm_pkg::cmd_t                          cmd,
	output glcm_pkg::sts_t                               sts,
	output logic [glcm_pkg::VALUE_BITS-1:0]              value,
	output logic                                         kind
);

	localparam int POS_BITS   = glcm_pkg::POS_BITS;
	localparam int SUM_BITS   = glcm_pkg::SUM_BITS;
	localparam int CFG_BITS   = glcm_pkg::CFG_BITS;
	localparam int FRAME_AW   = glcm_pkg::FRAME_AW;
	localparam int BIN_AW     = glcm_pkg::BIN_AW;
	localparam int COUNT_BITS = glcm_pkg::COUNT_BITS;
	localparam int VALUE_BITS = glcm_pkg::VALUE_BITS;
	localparam int PIX_BITS   = glcm_pkg::PIX_BITS;

	// Configuration registers.
	logic [CFG_BITS-1:0]        img_w_q;
	logic [CFG_BITS-1:0]        img_h_q;
	logic signed [CFG_BITS-1:0] off_x_q;
	logic signed [CFG_BITS-1:0] off_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= CFG_BITS'(256);
			img_h_q <= CFG_BITS'(256);
			off_x_q <= CFG_BITS'(1);
			off_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				glcm_pkg::CFG_WIDTH:    img_w_q <= cfg_data;
				glcm_pkg::CFG_HEIGHT:   img_h_q <= cfg_data;
				glcm_pkg::CFG_OFFSET_X: off_x_q <= $signed(cfg_data);
				glcm_pkg::CFG_OFFSET_Y: off_y_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Effective frame size, limited to the store.
	logic [CFG_BITS-1:0] w_eff;
	logic [CFG_BITS-1:0] h_eff;

	assign w_eff = (32'(img_w_q) > glcm_pkg::MAX_WIDTH) ?
		CFG_BITS'(glcm_pkg::MAX_WIDTH) : img_w_q;
	assign h_eff = (32'(img_h_q) > glcm_pkg::MAX_HEIGHT) ?
		CFG_BITS'(glcm_pkg::MAX_HEIGHT) : img_h_q;

	// Scan position of the reference pixel.
	logic [POS_BITS-1:0] c_q;
	logic [POS_BITS-1:0] r_q;
	logic                col_last;
	logic                row_last;

	assign col_last = (c_q == POS_BITS'(w_eff) - POS_BITS'(1));
	assign row_last = (r_q == POS_BITS'(h_eff) - POS_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (cmd.start_pass) begin
			c_q <= '0;
			r_q <= '0;
		end else if (cmd.advance) begin
			if (col_last) begin
				c_q <= '0;
				r_q <= r_q + POS_BITS'(1);
			end else begin
				c_q <= c_q + POS_BITS'(1);
			end
		end
	end

	// Neighbor position and frame bounds test.
	logic signed [SUM_BITS-1:0] nr;
	logic signed [SUM_BITS-1:0] nc;
	logic                       in_frame;

	assign nr = $signed(SUM_BITS'(r_q)) + SUM_BITS'(off_y_q);
	assign nc = $signed(SUM_BITS'(c_q)) + SUM_BITS'(off_x_q);
	assign in_frame = (nr >= 0) && (nr < $signed(SUM_BITS'(h_eff))) &&
		(nc >= 0) && (nc < $signed(SUM_BITS'(w_eff)));

	// Frame store: one write port for loads, two read ports for the pair.
	logic [PIX_BITS-1:0] frame_q [glcm_pkg::FRAME_DEPTH];
	logic [FRAME_AW-1:0] ld_addr;
	logic [FRAME_AW-1:0] ref_addr;
	logic [FRAME_AW-1:0] nbr_addr;
	logic                ld_ok;
	logic [PIX_BITS-1:0] pix_a_q;
	logic [PIX_BITS-1:0] pix_b_q;

	assign ld_ok    = (32'(row) < glcm_pkg::MAX_HEIGHT) && (32'(col) < glcm_pkg::MAX_WIDTH);
	assign ld_addr  = FRAME_AW'(32'(row) * glcm_pkg::MAX_WIDTH + 32'(col));
	assign ref_addr = FRAME_AW'(32'(r_q) * glcm_pkg::MAX_WIDTH + 32'(c_q));
	assign nbr_addr = FRAME_AW'(32'(nr[POS_BITS-1:0]) * glcm_pkg::MAX_WIDTH +
		32'(nc[POS_BITS-1:0]));

	always_ff @(posedge clk) begin
		if (cmd.load_pix && ld_ok) begin
			frame_q[ld_addr] <= pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			pix_a_q <= frame_q[ref_addr];
			pix_b_q <= frame_q[nbr_addr];
		end
	end

	// Bin store: one read port (pass or user read), one write port (update or clear).
	logic [COUNT_BITS-1:0] bin_q [glcm_pkg::BIN_DEPTH];
	logic [BIN_AW-1:0]     pass_idx;
	logic [BIN_AW-1:0]     user_idx;
	logic [BIN_AW-1:0]     rd_addr;
	logic [BIN_AW-1:0]     idx_q;
	logic [BIN_AW-1:0]     clr_q;
	logic [COUNT_BITS-1:0] bin_rd_q;
	logic [COUNT_BITS-1:0] bin_inc;
	logic [BIN_AW-1:0]     wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  wr_en;
	logic                  range_ok_q;

	assign pass_idx = BIN_AW'(32'(glcm_pkg::clamp_level(pix_a_q)) * glcm_pkg::LEVELS +
		32'(glcm_pkg::clamp_level(pix_b_q)));
	assign user_idx = BIN_AW'(32'(level_ref) * glcm_pkg::LEVELS + 32'(level_nbr));
	assign rd_addr  = cmd.bin_rd_user ? user_idx : pass_idx;
	assign bin_inc  = (&bin_rd_q) ? bin_rd_q : bin_rd_q + COUNT_BITS'(1);
	assign wr_en    = cmd.bin_wr || cmd.clr_step;
	assign wr_addr  = cmd.clr_step ? clr_q : idx_q;
	assign wr_data  = cmd.clr_step ? '0 : bin_inc;

	always_ff @(posedge clk) begin
		if (cmd.bin_rd_pass || cmd.bin_rd_user) begin
			bin_rd_q <= bin_q[rd_addr];
		end
		if (wr_en) begin
			bin_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bin_rd_pass) begin
			idx_q <= pass_idx;
		end
		if (cmd.bin_rd_user) begin
			range_ok_q <= (32'(level_ref) < glcm_pkg::LEVELS) &&
				(32'(level_nbr) < glcm_pkg::LEVELS);
		end
	end

	// Clearing sweep address; wraps back to zero after the last entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + BIN_AW'(1);
		end
	end

	// Pairs counted in the current pass, saturating at the result maximum.
	logic [VALUE_BITS-1:0] pairs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q <= '0;
		end else if (cmd.start_pass) begin
			pairs_q <= '0;
		end else if (cmd.bin_wr && !(&pairs_q)) begin
			pairs_q <= pairs_q + VALUE_BITS'(1);
		end
	end

	// Result register.
	logic [VALUE_BITS-1:0] value_q;
	logic                  kind_q;

	always_ff @(posedge clk) begin
		if (cmd.out_read) begin
			value_q <= range_ok_q ? glcm_pkg::sat_out(bin_rd_q) : '0;
			kind_q  <= glcm_pkg::KIND_READ;
		end else if (cmd.out_pass) begin
			value_q <= pairs_q;
			kind_q  <= glcm_pkg::KIND_PASS;
		end
	end

	assign value = value_q;
	assign kind  = kind_q;

	// Status to the controller.
	assign sts.frame_empty  = (w_eff == '0) || (h_eff == '0);
	assign sts.scan_last    = col_last && row_last;
	assign sts.nbr_in_frame = in_frame;
	assign sts.clr_last     = &clr_q;

endmodule

`default_nettype wire

@@ design/gray_level_cooccurrence_counter_unit.sv @@
// Top level of the gray-level co-occurrence counter: controller plus datapath.
`default_nettype none

// Each input transaction carries a mode. A load writes one pixel to the frame store. A
// read returns one bin count: the bin is read into a register, then placed in the result
// register once that is free. A counting pass walks the configured frame in row-major
// order and returns the number of pairs it counted: each pixel is fetched from the frame
// store, and each counted pair then takes a bin read and a bin write through the single
// read and write ports of the bin store; the result is posted once the output register is
// free. A clear, and the sweep that runs after reset, write zero to the LEVELS*LEVELS bins
// one per cycle; no input transaction is accepted meanwhile. Configuration writes are
// taken at any time but must only be issued while the block is idle. Results wait in an
// output register, so the next transaction is accepted while a result is still pending.
module gray_level_cooccurrence_counter_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [glcm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [glcm_pkg::CFG_BITS-1:0]         cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [glcm_pkg::MODE_BITS-1:0]        mode,
	input  wire logic [glcm_pkg::PIX_BITS-1:0]         pixel,
	input  wire logic [glcm_pkg::POSIN_BITS-1:0]       row,
	input  wire logic [glcm_pkg::POSIN_BITS-1:0]       col,
	input  wire logic [glcm_pkg::PIX_BITS-1:0]         level_ref,
	input  wire logic [glcm_pkg::PIX_BITS-1:0]         level_nbr,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [glcm_pkg::VALUE_BITS-1:0]           value,
	output logic                                      kind
);

	glcm_pkg::cmd_t cmd;
	glcm_pkg::sts_t sts;

	glcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	glcm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.row       (row),
		.col       (col),
		.level_ref (level_ref),
		.level_nbr (level_nbr),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.kind      (kind)
	);

endmodule

`default_nettype wire

@@ bench/glcm_checker.sv @@
// Checker for the co-occurrence counter: watches both channels, predicts every result, compares.
module glcm_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [glcm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [glcm_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [glcm_pkg::MODE_BITS-1:0]      mode,
	input  logic [glcm_pkg::PIX_BITS-1:0]       pixel,
	input  logic [glcm_pkg::POSIN_BITS-1:0]     row,
	input  logic [glcm_pkg::POSIN_BITS-1:0]     col,
	input  logic [glcm_pkg::PIX_BITS-1:0]       level_ref,
	input  logic [glcm_pkg::PIX_BITS-1:0]       level_nbr,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [glcm_pkg::VALUE_BITS-1:0]     value,
	input  logic                                kind,
	output int                                  mismatches,
	output int                                  outstanding,
	output int                                  compared
);
	timeunit 1ns;
	timeprecision 1ps;

	import glcm_pkg::*;

	localparam int unsigned TALLY_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);
	localparam longint unsigned VALUE_LIMIT = (64'd1 << VALUE_BITS) - 64'd1;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  kind;
	} bin_result_t;

	// Results still owed by the block, oldest first.
	bin_result_t pending_results[$];

	// Private copy of the frame, the bins and the frame settings.
	logic [PIX_BITS-1:0] frame_copy [FRAME_DEPTH];
	int unsigned         bin_tally [BIN_DEPTH];
	logic [CFG_BITS-1:0] cols_cfg;
	logic [CFG_BITS-1:0] rows_cfg;
	logic [CFG_BITS-1:0] dx_cfg;
	logic [CFG_BITS-1:0] dy_cfg;

	// A gray level past the bin range lands in the last bin.
	function automatic int unsigned bin_of(input int lv);
		return (lv >= LEVELS) ? LEVELS - 1 : lv;
	endfunction

	// Counts wider than the result field are reported at the field's maximum.
	function automatic logic [VALUE_BITS-1:0] cap_value(input longint unsigned v);
		return (v > VALUE_LIMIT) ? VALUE_BITS'(VALUE_LIMIT) : VALUE_BITS'(v);
	endfunction

	// One counting pass over the configured frame; updates the bins, returns the pair count.
	function automatic logic [VALUE_BITS-1:0] tally_offset_pairs();
		int w, h, dx, dy, r, c, nr, nc;
		int unsigned slot;
		longint unsigned pairs;
		w = (int'(cols_cfg) > MAX_WIDTH) ? MAX_WIDTH : int'(cols_cfg);
		h = (int'(rows_cfg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(rows_cfg);
		dx = $signed(dx_cfg);
		dy = $signed(dy_cfg);
		pairs = 0;
		for (r = 0; r < h; r++) begin
			for (c = 0; c < w; c++) begin
				nr = r + dy;
				nc = c + dx;
				if (nr >= 0 && nr < h && nc >= 0 && nc < w) begin
					slot = bin_of(frame_copy[r * MAX_WIDTH + c]) * LEVELS
						+ bin_of(frame_copy[nr * MAX_WIDTH + nc]);
					if (bin_tally[slot] < TALLY_MAX)
						bin_tally[slot]++;
					pairs++;
				end
			end
		end
		return cap_value(pairs);
	endfunction

	// Everything is sampled at the rising edge, before the edge's updates land.
	always @(posedge clk or negedge arst_n) begin
		bin_result_t want;
		if (!arst_n) begin
			cols_cfg = 9'd256;
			rows_cfg = 9'd256;
			dx_cfg = 9'd1;
			dy_cfg = 9'd0;
			pending_results.delete();
			mismatches = 0;
			compared = 0;
			outstanding <= 0;
		end else begin
			// Register writes must only be issued while the block is idle; the block does not enforce it.
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH:    cols_cfg = cfg_data;
					CFG_HEIGHT:   rows_cfg = cfg_data;
					CFG_OFFSET_X: dx_cfg = cfg_data;
					CFG_OFFSET_Y: dy_cfg = cfg_data;
				endcase
			end

			// Compare a delivered result against the oldest prediction.
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: value %0d, kind %0d with nothing expected",
						value, kind);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					compared++;
					if (value !== want.value) begin
						$error("value mismatch: expected %0d, actual %0d", want.value, value);
						mismatches++;
					end
					if (kind !== want.kind) begin
						$error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
						mismatches++;
					end
				end
			end

			// Predict the effect of an accepted input transaction.
			if (in_valid && in_ready) begin
				case (mode)
					MODE_LOAD:
						if (row < MAX_HEIGHT && col < MAX_WIDTH)
							frame_copy[row * MAX_WIDTH + col] = pixel;
					MODE_PASS: begin
						want.value = tally_offset_pairs();
						want.kind = KIND_PASS;
						pending_results.push_back(want);
					end
					MODE_READ: begin
						if (level_ref < LEVELS && level_nbr < LEVELS)
							want.value = cap_value(bin_tally[level_ref * LEVELS + level_nbr]);
						else
							want.value = '0;
						want.kind = KIND_READ;
						pending_results.push_back(want);
					end
					MODE_CLEAR:
						foreach (bin_tally[i])
							bin_tally[i] = 0;
				endcase
			end

			outstanding <= pending_results.size();
		end
	end

endmodule

@@ bench/tb.sv @@
// Top of the co-occurrence counter bench: clock, reset, stimulus, receiver and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import glcm_pkg::*;

	localparam int RANDOM_ITEMS = 900;
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_PHASE   = 6;
	localparam int STEADY_PHASE = 7;
	localparam int MAX_CLEARS   = 4;
	localparam int CYCLE_LIMIT  = 2_000_000;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]     cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [MODE_BITS-1:0]    mode;
	logic [PIX_BITS-1:0]     pixel;
	logic [POSIN_BITS-1:0]   row;
	logic [POSIN_BITS-1:0]   col;
	logic [PIX_BITS-1:0]     level_ref;
	logic [PIX_BITS-1:0]     level_nbr;
	logic                    out_valid;
	logic                    out_ready;
	logic [VALUE_BITS-1:0]   value;
	logic                    kind;

	int mismatches;
	int outstanding;
	int compared;

	// Shared between the sender and the receiver.
	bit steady;
	bit hold_armed;

	// Stimulus bookkeeping.
	int n_loads, n_passes, n_reads, n_clears, n_settings, n_items, n_phase;
	bit                  loaded_map [FRAME_DEPTH];
	logic [PIX_BITS-1:0] phase_levels[$];
	logic [PIX_BITS-1:0] palette [4];
	int                  palette_size;

	gray_level_cooccurrence_counter_unit dut (.*);

	glcm_checker pair_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .pixel(pixel), .row(row), .col(col),
		.level_ref(level_ref), .level_nbr(level_nbr),
		.out_valid(out_valid), .out_ready(out_ready), .value(value), .kind(kind),
		.mismatches(mismatches), .outstanding(outstanding), .compared(compared)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one input transaction, after random idle cycles unless steady, and hold it until taken.
	task automatic push_item(input logic [MODE_BITS-1:0] m, input logic [PIX_BITS-1:0] p,
			input logic [POSIN_BITS-1:0] r, c, input logic [PIX_BITS-1:0] lr, ln);
		if (!steady) begin
			while ($urandom_range(99) < 16) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		mode <= m;
		pixel <= p;
		row <= r;
		col <= c;
		level_ref <= lr;
		level_nbr <= ln;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_items++;
		case (m)
			MODE_LOAD:  n_loads++;
			MODE_PASS:  n_passes++;
			MODE_READ:  n_reads++;
			MODE_CLEAR: n_clears++;
		endcase
	endtask

	task automatic load_pixel(input logic [POSIN_BITS-1:0] r, c, input logic [PIX_BITS-1:0] p);
		loaded_map[r * MAX_WIDTH + c] = 1'b1;
		push_item(MODE_LOAD, p, r, c, 8'($urandom), 8'($urandom));
	endtask

	task automatic read_bin(input logic [PIX_BITS-1:0] lr, ln);
		push_item(MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom), lr, ln);
	endtask

	task automatic run_pass();
		push_item(MODE_PASS, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom));
	endtask

	task automatic clear_bins();
		push_item(MODE_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom));
	endtask

	// Stop sending and wait until every owed result has been delivered.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four frame registers on consecutive cycles.
	task automatic apply_settings(input logic [CFG_BITS-1:0] w, h, dx, dy);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_index <= CFG_OFFSET_X;
		cfg_data <= dx;
		@(posedge clk);
		cfg_index <= CFG_OFFSET_Y;
		cfg_data <= dy;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [PIX_BITS-1:0] pick_level();
		if (palette_size == 0)
			return 8'($urandom);
		return palette[$urandom_range(palette_size - 1)];
	endfunction

	// Load the frame region; small frames fresh, large ones where still unwritten or by chance.
	// Stray loads to random positions are mixed in.
	task automatic fill_frame(input int ew, eh);
		int r, c;
		logic [PIX_BITS-1:0] lv;
		for (r = 0; r < eh; r++) begin
			for (c = 0; c < ew; c++) begin
				if (!loaded_map[r * MAX_WIDTH + c] || ew * eh <= 64 || $urandom_range(15) == 0) begin
					lv = pick_level();
					load_pixel(8'(r), 8'(c), lv);
					phase_levels.push_back(lv);
				end
				if ($urandom_range(15) == 0)
					load_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			end
		end
	endtask

	// Read a bin that the frame likely hit, or a random one.
	task automatic probe_bin();
		int n;
		n = phase_levels.size();
		if (n > 0 && $urandom_range(3) != 0)
			read_bin(phase_levels[$urandom_range(n - 1)], phase_levels[$urandom_range(n - 1)]);
		else
			read_bin(8'($urandom), 8'($urandom));
	endtask

	// Receiver: random stalls, one long hold-off on request, and a stall-free stretch.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_armed) begin
				hold_armed = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 16);
			end
			@(posedge clk);
		end
	end

	// Watchdog on the whole run.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		int w, h, dx, dy, ew, eh, sel, random_start;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_LOAD;
		pixel = '0;
		row = '0;
		col = '0;
		level_ref = '0;
		level_nbr = '0;
		palette_size = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Bins are zero after reset; these reads also wait out the clearing sweep.
		read_bin(8'd0, 8'd0);
		read_bin(8'd255, 8'd255);
		settle();

		// Small known frame with level extremes and one pixel at the far corner.
		apply_settings(9'd4, 9'd2, 9'd1, 9'd0);
		load_pixel(8'd0, 8'd0, 8'd0);
		load_pixel(8'd0, 8'd1, 8'd255);
		load_pixel(8'd0, 8'd2, 8'd255);
		load_pixel(8'd0, 8'd3, 8'd0);
		load_pixel(8'd1, 8'd0, 8'd170);
		load_pixel(8'd1, 8'd1, 8'd85);
		load_pixel(8'd1, 8'd2, 8'd0);
		load_pixel(8'd1, 8'd3, 8'd255);
		load_pixel(8'd255, 8'd255, 8'hA5);
		run_pass();
		read_bin(8'd0, 8'd255);
		read_bin(8'd255, 8'd0);
		read_bin(8'd170, 8'd85);
		clear_bins();
		read_bin(8'd0, 8'd255);
		settle();

		// Zero-width frame: the pass counts nothing.
		apply_settings(9'd0, 9'd2, 9'h1FF, 9'd1);
		run_pass();
		read_bin(8'd85, 8'd0);
		settle();

		// Random phases: set the frame, load it, run passes, read bins back.
		random_start = n_items;
		n_phase = 0;
		while (n_items - random_start < RANDOM_ITEMS) begin
			n_phase++;
			sel = (n_phase <= 5) ? n_phase - 1 : $urandom_range(11);
			case (sel)
				0: begin
					w = $urandom_range(257, 511);
					h = 1;
				end
				1: begin
					if (n_phase > 2 && $urandom_range(1)) begin
						w = 256;
						h = 1;
					end else begin
						w = 1;
						h = 256;
					end
				end
				2: begin
					w = 1;
					h = $urandom_range(257, 511);
				end
				3: begin
					if ($urandom_range(1)) begin
						w = 0;
						h = $urandom_range(0, 8);
					end else begin
						w = $urandom_range(1, 8);
						h = 0;
					end
				end
				default: begin
					w = $urandom_range(1, 8);
					h = $urandom_range(1, 8);
				end
			endcase
			ew = (w > MAX_WIDTH) ? MAX_WIDTH : w;
			eh = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;

			case ((n_phase <= 2) ? 1 : $urandom_range(7))
				0: begin
					dx = $urandom_range(511);
					dy = $urandom_range(511);
				end
				1: begin
					case ($urandom_range(3))
						0: dx = 255;
						1: dx = -255;
						2: dx = -256;
						3: dx = 0;
					endcase
					case ($urandom_range(3))
						0: dy = 0;
						1: dy = 255;
						2: dy = -255;
						3: dy = -256;
					endcase
				end
				default: begin
					dx = $urandom_range(6) - 3;
					dy = $urandom_range(6) - 3;
				end
			endcase

			apply_settings(9'(w), 9'(h), 9'(dx), 9'(dy));
			palette_size = $urandom_range(4);
			foreach (palette[i])
				palette[i] = 8'($urandom);
			phase_levels.delete();
			steady = (n_phase == STEADY_PHASE);
			if (n_phase == HOLD_PHASE)
				hold_armed = 1'b1;

			fill_frame(ew, eh);
			repeat ($urandom_range(1, 2)) run_pass();
			repeat ((n_phase == HOLD_PHASE) ? 14 : $urandom_range(3, 10)) probe_bin();
			if (n_clears < MAX_CLEARS && n_phase % 8 == 3) begin
				clear_bins();
				probe_bin();
			end
			settle();
		end
		steady = 1'b0;

		// Every read and pass is answered; give any stray result time to show up.
		repeat (16) @(posedge clk);
		$display("Sent %0d loads, %0d counting passes, %0d bin reads and %0d clears",
			n_loads, n_passes, n_reads, n_clears);
		$display("over %0d frame settings; %0d results compared.", n_settings, compared);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
